// ----- rtl/core/salru_pkg.sv -----
package salru_pkg;

    localparam int SET_BITS     = 8;
    localparam int WAYS         = 1;
    localparam int OFFSET_BITS  = 4;
    localparam int ADDRESS_BITS = 32;

    localparam int ADDR_W   = 32;
    localparam int SETIDX_W = 8;
    localparam int CNT_W    = 32;
    localparam int STAMP_W  = 32;
    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int TAG_LSB  = OFFSET_BITS + SET_BITS;
    localparam int TAG_W    = ADDRESS_BITS - TAG_LSB;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [SET_BITS-1:0] t_set;
    typedef logic [TAG_W-1:0]    t_tag;
    typedef logic [STAMP_W-1:0]  t_stamp;
    typedef logic [WAY_W-1:0]    t_way_idx;
    typedef logic [WAYS-1:0]     t_way_mask;

    typedef struct packed {
        t_tag   tag;
        t_stamp stamp;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    // Outcome of the tag compare and replacement choice for one set.
    typedef struct packed {
        logic     hit;
        t_way_idx way;
    } t_sel;

endpackage

// ----- rtl/core/salru_req_if.sv -----
interface salru_req_if import salru_pkg::*; ();
    logic  valid;
    logic  ready;
    t_addr address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

// ----- rtl/core/salru_rsp_if.sv -----
interface salru_rsp_if import salru_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [SETIDX_W-1:0] set_index;
    logic [CNT_W-1:0]    hit_total;
    logic [CNT_W-1:0]    miss_total;

    modport source (output valid, output hit, output set_index, output hit_total,
                    output miss_total, input ready);
    modport sink   (input valid, input hit, input set_index, input hit_total,
                    input miss_total, output ready);
endinterface

// ----- rtl/core/salru_store.sv -----
module salru_store import salru_pkg::*; (
    input  logic i_clk,
    input  logic i_rd_en,
    input  t_set i_rd_set,
    output t_row o_rd_row,
    input  logic i_wr_en,
    input  t_set i_wr_set,
    input  t_row i_wr_row
);

    t_row r_mem [NUM_SETS];
    t_row r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_set];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// ----- rtl/core/salru_way_sel.sv -----
module salru_way_sel import salru_pkg::*; (
    input  t_row      i_row,
    input  t_way_mask i_valid,
    input  t_tag      i_tag,
    output t_sel      o_sel
);

    logic     hit;
    t_way_idx hit_way;
    t_way_idx victim;
    t_stamp   best;

    // Invalid ways never hit and read as stamp zero, so they win the victim search.
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_valid[w] && i_row[w].tag == i_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        victim = '0;
        best   = i_valid[0] ? i_row[0].stamp : '0;
        for (int w = 1; w < WAYS; w++) begin
            if ((i_valid[w] ? i_row[w].stamp : t_stamp'(0)) < best) begin
                best   = i_valid[w] ? i_row[w].stamp : t_stamp'(0);
                victim = WAY_W'(w);
            end
        end
        o_sel.hit = hit;
        o_sel.way = hit ? hit_way : victim;
    end

endmodule

// ----- rtl/core/set_assoc_cache_tag_lru.sv -----
// Tag and LRU replacement unit of a set-associative cache. Each request carries
// a byte address; the block looks up its set, reports hit or miss, and on a
// miss installs the tag in the least recently used way (invalid ways first,
// lowest way on a tie), returning the running hit and miss totals. A request
// reads the set's row of tags and stamps from the synchronous tag memory when
// it is accepted, then in ST_LOOK compares, chooses a way and writes the row
// back; no new request is taken while in ST_LOOK. The response sits in
// an output register; while it waits the input is held off, and the next
// request can be taken in the same cycle as the waiting response is accepted.
// Valid bits live in flip-flops cleared by reset, so no clearing pass is needed
// and the block accepts requests in the first cycle after reset.
module set_assoc_cache_tag_lru import salru_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    salru_req_if.sink         i_req,
    salru_rsp_if.source       o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_set                r_set;
    t_tag                r_tag;
    t_stamp              r_clock;
    logic [CNT_W-1:0]    r_hit_cnt;
    logic [CNT_W-1:0]    r_miss_cnt;
    logic [CNT_W-1:0]    n_hit_cnt;
    logic [CNT_W-1:0]    n_miss_cnt;
    t_way_mask           r_valid [NUM_SETS];
    logic                r_rsp_valid;
    logic                r_rsp_hit;
    logic [SETIDX_W-1:0] r_rsp_set;
    logic [CNT_W-1:0]    r_rsp_hit_total;
    logic [CNT_W-1:0]    r_rsp_miss_total;

    logic   accept;
    logic   look;
    t_set   req_set;
    t_tag   req_tag;
    t_row   rd_row;
    t_row   wr_row;
    t_sel   sel;
    t_stamp new_stamp;

    assign i_req.ready = (r_state == ST_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign look        = (r_state == ST_LOOK);
    assign req_set     = i_req.address[OFFSET_BITS +: SET_BITS];
    assign req_tag     = i_req.address[ADDRESS_BITS-1:TAG_LSB];
    assign new_stamp   = r_clock + t_stamp'(1);

    salru_store u_store (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_set (req_set),
        .o_rd_row (rd_row),
        .i_wr_en  (look),
        .i_wr_set (r_set),
        .i_wr_row (wr_row)
    );

    salru_way_sel u_way_sel (
        .i_row   (rd_row),
        .i_valid (r_valid[r_set]),
        .i_tag   (r_tag),
        .o_sel   (sel)
    );

    always_comb begin
        wr_row = rd_row;
        for (int w = 0; w < WAYS; w++) begin
            if (!r_valid[r_set][w]) begin
                wr_row[w] = '0;
            end
        end
        wr_row[sel.way].tag   = r_tag;
        wr_row[sel.way].stamp = new_stamp;
        n_hit_cnt  = r_hit_cnt + CNT_W'(sel.hit);
        n_miss_cnt = r_miss_cnt + CNT_W'(!sel.hit);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clock     <= t_stamp'(1);
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_rsp_valid <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (look) begin
                r_clock                  <= new_stamp;
                r_hit_cnt                <= n_hit_cnt;
                r_miss_cnt               <= n_miss_cnt;
                r_valid[r_set][sel.way]  <= 1'b1;
                r_rsp_valid              <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= req_set;
            r_tag <= req_tag;
        end
        if (look) begin
            r_rsp_hit        <= sel.hit;
            r_rsp_set        <= SETIDX_W'(r_set);
            r_rsp_hit_total  <= n_hit_cnt;
            r_rsp_miss_total <= n_miss_cnt;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.hit        = r_rsp_hit;
    assign o_rsp.set_index  = r_rsp_set;
    assign o_rsp.hit_total  = r_rsp_hit_total;
    assign o_rsp.miss_total = r_rsp_miss_total;

endmodule

// ----- bench/tb_set_assoc_cache_tag_lru.sv -----
`timescale 1ns / 100ps

module tb_set_assoc_cache_tag_lru;
    import salru_pkg::*;

    localparam int    CYCLE_LIMIT   = 400000;
    localparam int    DRAIN_CYCLES  = 8;
    localparam int    PHASES        = 8;
    localparam int    PHASE_ITEMS   = 200;
    localparam int    MAX_REPORTS   = 100;
    localparam t_addr OFFSET_MASK   = (t_addr'(1) << OFFSET_BITS) - t_addr'(1);
    localparam int    DIRECTED_ROWS = 18;

    typedef struct packed {
        logic                hit;
        logic [SETIDX_W-1:0] set_index;
        logic [CNT_W-1:0]    hit_total;
        logic [CNT_W-1:0]    miss_total;
    } t_access_result;

    typedef struct packed {
        t_addr          address;
        logic           typed;
        t_access_result want;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    salru_req_if req_ch ();
    salru_rsp_if rsp_ch ();

    set_assoc_cache_tag_lru DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Expected cache contents, tracked in step with the accepted requests.
    t_tag             line_tag   [NUM_SETS][WAYS];
    logic             line_valid [NUM_SETS][WAYS];
    t_stamp           line_stamp [NUM_SETS][WAYS];
    t_stamp           recency_clock;
    logic [CNT_W-1:0] hits_so_far;
    logic [CNT_W-1:0] misses_so_far;

    t_access_result expected_responses[$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             stall_left = 0;
    bit             calm_phase = 1'b0;
    t_tag           hot_tags [4];
    t_set           hot_sets [6];

    // Rows with typed = 1 carry results that follow from reset by hand.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd1}},
        '{32'h0000_000F, 1'b1, '{1'b1, 8'h00, 32'd1, 32'd1}},
        '{32'hFFFF_FFFF, 1'b1, '{1'b0, 8'hFF, 32'd1, 32'd2}},
        '{32'hFFFF_FFF0, 1'b1, '{1'b1, 8'hFF, 32'd2, 32'd2}},
        '{32'h0000_0FF0, 1'b1, '{1'b0, 8'hFF, 32'd2, 32'd3}},
        '{32'hFFFF_FFFF, 1'b1, '{1'b0, 8'hFF, 32'd2, 32'd4}},
        '{32'h0000_0000, 1'b1, '{1'b1, 8'h00, 32'd3, 32'd4}},
        '{32'h0000_1000, 1'b1, '{1'b0, 8'h00, 32'd3, 32'd5}},
        '{32'h0000_0008, 1'b1, '{1'b0, 8'h00, 32'd3, 32'd6}},
        '{32'h0000_0010, 1'b1, '{1'b0, 8'h01, 32'd3, 32'd7}},
        '{32'h0000_0014, 1'b1, '{1'b1, 8'h01, 32'd4, 32'd7}},
        '{32'h8000_0000, 1'b1, '{1'b0, 8'h00, 32'd4, 32'd8}},
        '{32'h8000_0004, 1'b1, '{1'b1, 8'h00, 32'd5, 32'd8}},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h5555_5550, 1'b0, '0},
        '{32'h0000_0FFF, 1'b0, '0},
        '{32'h0000_0FF8, 1'b0, '0}
    };

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void clear_cache_model();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                line_stamp[s][w] = '0;
            end
        end
        recency_clock = t_stamp'(1);
        hits_so_far   = '0;
        misses_so_far = '0;
    endfunction

    // Looks one address up in the expected cache and updates it.
    function automatic t_access_result lookup_access(input t_addr addr);
        t_set           set_no;
        t_tag           tag;
        logic           found;
        int             victim;
        t_access_result res;
        set_no = t_set'(addr >> OFFSET_BITS);
        tag    = t_tag'(addr >> TAG_LSB);
        found  = 1'b0;
        victim = 0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && line_valid[set_no][w] && line_tag[set_no][w] == tag) begin
                found = 1'b1;
                recency_clock = recency_clock + t_stamp'(1);
                line_stamp[set_no][w] = recency_clock;
            end
        end
        if (found) begin
            hits_so_far = hits_so_far + CNT_W'(1);
        end else begin
            // Invalid ways keep stamp zero, so they are chosen as victim before any used way.
            for (int w = 1; w < WAYS; w++) begin
                if (line_stamp[set_no][w] < line_stamp[set_no][victim]) begin
                    victim = w;
                end
            end
            line_tag[set_no][victim]   = tag;
            line_valid[set_no][victim] = 1'b1;
            recency_clock = recency_clock + t_stamp'(1);
            line_stamp[set_no][victim] = recency_clock;
            misses_so_far = misses_so_far + CNT_W'(1);
        end
        res.hit        = found;
        res.set_index  = SETIDX_W'(set_no);
        res.hit_total  = hits_so_far;
        res.miss_total = misses_so_far;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Mostly accesses to a few hot sets and tags so that hits, conflict
    // evictions and back-to-back accesses to one set are common.
    function automatic t_addr pick_address(input t_addr previous);
        int    r;
        t_set  set_no;
        t_tag  tag;
        t_addr a;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            a = t_addr'($urandom);
        end else if (r < 35) begin
            a = (previous & ~OFFSET_MASK) | (t_addr'($urandom) & OFFSET_MASK);
        end else begin
            set_no = ($urandom_range(0, 4) == 0) ? t_set'($urandom)
                                                 : hot_sets[$urandom_range(0, 5)];
            tag    = hot_tags[$urandom_range(0, 3)];
            a = (t_addr'(tag) << TAG_LSB) | (t_addr'(set_no) << OFFSET_BITS)
                | (t_addr'($urandom) & OFFSET_MASK);
        end
        return a;
    endfunction

    function automatic void refresh_hot_pools();
        for (int i = 0; i < 4; i++) begin
            hot_tags[i] = t_tag'($urandom);
        end
        for (int i = 0; i < 6; i++) begin
            hot_sets[i] = t_set'($urandom);
        end
        if ($urandom_range(0, 1) == 0) begin
            hot_tags[0] = '1;
            hot_tags[1] = '0;
            hot_sets[0] = '1;
            hot_sets[1] = '0;
        end
    endfunction

    task automatic send_request(input t_addr a, input logic typed,
                                input t_access_result typed_want);
        t_access_result predicted;
        req_ch.valid   <= 1'b1;
        req_ch.address <= a;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = lookup_access(a);
        expected_responses.push_back(typed ? typed_want : predicted);
        @(negedge i_clk);
    endtask

    task automatic idle_between_requests();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid   <= 1'b0;
            req_ch.address <= t_addr'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic report_field(input string field, input logic [CNT_W-1:0] want,
                                input logic [CNT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    task automatic check_response();
        t_access_result want;
        if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: response expected none, got hit=%0b set=%0h", $time,
                         rsp_ch.hit, rsp_ch.set_index);
            end
        end else begin
            want = expected_responses.pop_front();
            if (rsp_ch.hit !== want.hit) begin
                report_field("hit", CNT_W'(want.hit), CNT_W'(rsp_ch.hit));
            end
            if (rsp_ch.set_index !== want.set_index) begin
                report_field("set_index", CNT_W'(want.set_index), CNT_W'(rsp_ch.set_index));
            end
            if (rsp_ch.hit_total !== want.hit_total) begin
                report_field("hit_total", want.hit_total, rsp_ch.hit_total);
            end
            if (rsp_ch.miss_total !== want.miss_total) begin
                report_field("miss_total", want.miss_total, rsp_ch.miss_total);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            check_response();
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_addr last_address;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.address = '0;
        clear_cache_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_request(directed_rows[i].address, directed_rows[i].typed,
                         directed_rows[i].want);
            idle_between_requests();
        end

        // Odd phases run with no idling on either side.
        last_address = '0;
        for (int p = 0; p < PHASES; p++) begin
            calm_phase = p[0];
            refresh_hot_pools();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                last_address = pick_address(last_address);
                send_request(last_address, 1'b0, '0);
                idle_between_requests();
            end
        end
        req_ch.valid <= 1'b0;
        calm_phase = 1'b0;

        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/salru_pkg.sv
rtl/core/salru_req_if.sv
rtl/core/salru_rsp_if.sv
rtl/core/salru_store.sv
rtl/core/salru_way_sel.sv
rtl/core/set_assoc_cache_tag_lru.sv
bench/tb_set_assoc_cache_tag_lru.sv
